[design/ising_pkg.sv]
// ============================================================================
// Ising spin update package
// Shared field widths, command codes, queue entry and state types.
// ============================================================================
package ising_pkg;

    localparam int VERTEX_W    = 10;
    localparam int SLOT_W      = 3;
    localparam int NEIGHBOR_W  = 10;
    localparam int WEIGHT_W    = 8;
    localparam int RANDOM_W    = 16;
    localparam int TABLE_AW    = 10;
    localparam int THRESH_W    = 17;
    localparam int DE_W        = 12;
    localparam int TABLE_DEPTH = 1024;
    localparam int DE_MAX      = 2047;
    localparam int DE_MIN      = -2048;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_LOAD_EDGE   = 3'd0,
        CMD_SET_SPIN    = 3'd1,
        CMD_LOAD_THRESH = 3'd2,
        CMD_METRO       = 3'd3,
        CMD_GREEDY      = 3'd4,
        CMD_READ        = 3'd5
    } command_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_EDGE,
        OP_SPIN,
        OP_THRESH,
        OP_METRO,
        OP_GREEDY,
        OP_READ
    } op_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SELF,
        ST_TRY,
        ST_ENERGY,
        ST_FINISH
    } back_state_t;

    typedef struct packed {
        logic [2:0]                 command;
        logic [VERTEX_W-1:0]        vertex;
        logic [SLOT_W-1:0]          slot;
        logic [NEIGHBOR_W-1:0]      neighbor;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       spin_bit;
        logic [RANDOM_W-1:0]        random_word;
        logic [TABLE_AW-1:0]        table_index;
        logic [THRESH_W-1:0]        table_value;
    } in_item_t;

    typedef struct packed {
        logic                   flipped;
        logic                   spin_now;
        logic signed [DE_W-1:0] energy_change;
    } out_item_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic                       slot_ok;
        logic [VERTEX_W-1:0]        vertex;
        logic [SLOT_W-1:0]          slot;
        logic [NEIGHBOR_W-1:0]      neighbor;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       spin_bit;
        logic [RANDOM_W-1:0]        random_word;
        logic [TABLE_AW-1:0]        table_index;
        logic [THRESH_W-1:0]        table_value;
    } op_t;

endpackage

[design/ising_front.sv]
// ============================================================================
// Ising spin update front end
// Decodes and range-checks incoming commands and queues them for execution.
// ============================================================================
module ising_front #(
    parameter int NUM_VERTICES = 1024,
    parameter int MAX_DEGREE   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hold,
    input  logic              push,
    output logic              full,
    input  ising_pkg::in_item_t item,
    output logic              op_valid,
    input  logic              op_take,
    output ising_pkg::op_t    op
);
    import ising_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [16:0]      VERTEX_LIMIT = 17'(NUM_VERTICES);
    localparam logic [6:0]       SLOT_LIMIT   = 7'(MAX_DEGREE);
    localparam logic [CNT_W-1:0] COUNT_FULL   = CNT_W'(QUEUE_DEPTH);

    op_t              classified;
    logic             accept;
    op_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Decode the command; a bad command code or vertex becomes a no-op.
    always_comb
    begin
        classified             = '0;
        classified.vertex      = item.vertex;
        classified.slot        = item.slot;
        classified.neighbor    = item.neighbor;
        classified.weight      = item.weight;
        classified.spin_bit    = item.spin_bit;
        classified.random_word = item.random_word;
        classified.table_index = item.table_index;
        classified.table_value = item.table_value;
        classified.slot_ok     = (7'(item.slot) < SLOT_LIMIT);
        case (item.command)
            CMD_LOAD_EDGE:   classified.kind = OP_EDGE;
            CMD_SET_SPIN:    classified.kind = OP_SPIN;
            CMD_LOAD_THRESH: classified.kind = OP_THRESH;
            CMD_METRO:       classified.kind = OP_METRO;
            CMD_GREEDY:      classified.kind = OP_GREEDY;
            CMD_READ:        classified.kind = OP_READ;
            default:         classified.kind = OP_NOP;
        endcase
        if ({7'b0, item.vertex} >= VERTEX_LIMIT)
        begin
            classified.kind = OP_NOP;
        end
    end

    assign full     = hold || (count_reg == COUNT_FULL);
    assign accept   = push && !full;
    assign op_valid = (count_reg != '0);
    assign op       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = op_take ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({accept, op_take})
            2'b10:   count_next = CNT_W'(count_reg + 1'b1);
            2'b01:   count_next = CNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

[design/ising_back.sv]
// ============================================================================
// Ising spin update back end
// Owns the spin, coupling and threshold memories and runs one command at a
// time: neighbor sum, energy change, acceptance and the result register.
// ============================================================================
module ising_back #(
    parameter int NUM_VERTICES = 1024,
    parameter int MAX_DEGREE   = 8,
    parameter int WEIGHT_BITS  = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    output logic                 op_take,
    input  ising_pkg::op_t       op,
    output logic                 clearing,
    output logic                 empty,
    input  logic                 pop,
    output ising_pkg::out_item_t result
);
    import ising_pkg::*;

    localparam int VIDX_W     = $clog2(NUM_VERTICES);
    localparam int EDGE_DEPTH = NUM_VERTICES * MAX_DEGREE;
    localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
    localparam int EDGE_W     = NEIGHBOR_W + WEIGHT_BITS;
    localparam int K_W        = $clog2(MAX_DEGREE + 1);
    localparam int ACC_RAW    = WEIGHT_BITS + $clog2(MAX_DEGREE) + 3;
    localparam int ACC_W      = (ACC_RAW > 13) ? ACC_RAW : 13;
    localparam int CLEAR_LEN  = (EDGE_DEPTH > TABLE_DEPTH) ? EDGE_DEPTH : TABLE_DEPTH;
    localparam int CLR_W      = $clog2(CLEAR_LEN);

    localparam logic [16:0]             VERTEX_LIMIT = 17'(NUM_VERTICES);
    localparam logic [CLR_W:0]          CLR_LAST     = (CLR_W + 1)'(CLEAR_LEN - 1);
    localparam logic [CLR_W:0]          CLR_EDGE     = (CLR_W + 1)'(EDGE_DEPTH);
    localparam logic [CLR_W:0]          CLR_SPIN     = (CLR_W + 1)'(NUM_VERTICES);
    localparam logic [CLR_W:0]          CLR_TABLE    = (CLR_W + 1)'(TABLE_DEPTH);
    localparam logic [K_W-1:0]          K_LAST       = K_W'(MAX_DEGREE);
    localparam logic [EDGE_AW-1:0]      DEGREE_A     = EDGE_AW'(MAX_DEGREE);
    localparam logic signed [ACC_W-1:0] DE_HI        = ACC_W'(DE_MAX);
    localparam logic signed [ACC_W-1:0] DE_LO        = ACC_W'(DE_MIN);
    localparam logic [ACC_W-1:0]        TI_LAST      = ACC_W'(TABLE_DEPTH - 1);
    localparam logic [TABLE_AW-1:0]     TI_MAX       = TABLE_AW'(TABLE_DEPTH - 1);

    // Memories
    logic [EDGE_W-1:0]   edge_mem [EDGE_DEPTH];
    logic                spin_mem [NUM_VERTICES];
    logic [THRESH_W-1:0] thr_mem  [TABLE_DEPTH];

    logic                edge_we, edge_re;
    logic [EDGE_AW-1:0]  edge_waddr, edge_raddr;
    logic [EDGE_W-1:0]   edge_wdata, edge_q_reg;
    logic                spin_we, spin_re, spin_wdata, spin_q_reg;
    logic [VIDX_W-1:0]   spin_waddr, spin_raddr;
    logic                thr_we, thr_re;
    logic [TABLE_AW-1:0] thr_waddr, thr_raddr;
    logic [THRESH_W-1:0] thr_wdata, thr_q_reg;

    // Control state
    back_state_t         state_reg, state_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic                edge_pend_reg, edge_pend_next;
    logic                spin_pend_reg, spin_pend_next;
    logic                self_pend_reg, self_pend_next;
    logic                res_valid_reg, res_valid_next;

    // Payload state
    op_t                     op_reg, op_next;
    logic [VIDX_W-1:0]       vidx_reg, vidx_next;
    logic [EDGE_AW-1:0]      edge_addr_reg, edge_addr_next;
    logic [WEIGHT_BITS-1:0]  w_pend_reg, w_pend_next;
    logic signed [ACC_W-1:0] h_reg, h_next;
    logic                    self_spin_reg, self_spin_next;
    logic signed [ACC_W-1:0] de_reg, de_next;
    out_item_t               res_reg, res_next;

    // Datapath helpers
    logic [VIDX_W-1:0]       vidx_in;
    logic [EDGE_AW-1:0]      edge_addr_in;
    logic                    is_try;
    logic [NEIGHBOR_W-1:0]   edge_nb;
    logic [WEIGHT_BITS-1:0]  edge_w;
    logic                    nb_ok;
    logic signed [ACC_W-1:0] w_ext, h2, de_calc;
    logic [ACC_W-1:0]        ti_wide;
    logic [TABLE_AW-1:0]     thr_idx;
    logic [15:0]             weight_wide;
    logic                    de_neg, accept_rnd, flip, out_free;
    logic signed [DE_W-1:0]  de_sat;

    assign vidx_in      = VIDX_W'(op.vertex);
    assign edge_addr_in = EDGE_AW'(EDGE_AW'(vidx_in) * DEGREE_A)
                        + ((op.kind == OP_EDGE) ? EDGE_AW'(op.slot) : '0);
    assign is_try       = (op_reg.kind == OP_METRO) || (op_reg.kind == OP_GREEDY)
                       || (op_reg.kind == OP_READ);
    assign edge_nb      = edge_q_reg[EDGE_W-1:WEIGHT_BITS];
    assign edge_w       = edge_q_reg[WEIGHT_BITS-1:0];
    assign nb_ok        = ({7'b0, edge_nb} < VERTEX_LIMIT);
    assign w_ext        = {{(ACC_W - WEIGHT_BITS){w_pend_reg[WEIGHT_BITS-1]}}, w_pend_reg};
    assign h2           = h_reg <<< 1;
    assign de_calc      = self_spin_reg ? -h2 : h2;
    assign ti_wide      = ACC_W'(de_calc) >> 1;
    assign thr_idx      = (ti_wide > TI_LAST) ? TI_MAX : ti_wide[TABLE_AW-1:0];
    assign weight_wide  = {{8{op_reg.weight[7]}}, op_reg.weight};
    assign de_neg       = de_reg[ACC_W-1];
    assign accept_rnd   = ({1'b0, op_reg.random_word} < thr_q_reg);
    assign flip         = ((op_reg.kind == OP_METRO) && (de_neg || accept_rnd))
                       || ((op_reg.kind == OP_GREEDY) && de_neg);
    assign out_free     = !res_valid_reg || pop;
    assign de_sat       = (de_reg > DE_HI) ? DE_W'(DE_MAX)
                        : (de_reg < DE_LO) ? DE_W'(DE_MIN) : de_reg[DE_W-1:0];

    assign clearing = (state_reg == ST_CLEAR);
    assign empty    = !res_valid_reg;
    assign result   = res_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if ({1'b0, clr_reg} == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = (op.kind == OP_NOP) ? ST_FINISH : ST_SELF;
                end
            end
            ST_SELF:
            begin
                state_next = is_try ? ST_TRY : ST_ENERGY;
            end
            ST_TRY:
            begin
                if ((k_reg == K_LAST) && !edge_pend_reg && !spin_pend_reg)
                begin
                    state_next = ST_ENERGY;
                end
            end
            ST_ENERGY:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory controls and datapath updates
    always_comb
    begin
        op_take        = 1'b0;
        edge_we        = 1'b0;
        edge_waddr     = edge_addr_reg;
        edge_wdata     = '0;
        edge_re        = 1'b0;
        edge_raddr     = edge_addr_reg;
        spin_we        = 1'b0;
        spin_waddr     = vidx_reg;
        spin_wdata     = 1'b0;
        spin_re        = 1'b0;
        spin_raddr     = vidx_reg;
        thr_we         = 1'b0;
        thr_waddr      = op_reg.table_index;
        thr_wdata      = op_reg.table_value;
        thr_re         = 1'b0;
        thr_raddr      = thr_idx;
        clr_next       = clr_reg;
        op_next        = op_reg;
        vidx_next      = vidx_reg;
        edge_addr_next = edge_addr_reg;
        k_next         = k_reg;
        edge_pend_next = 1'b0;
        spin_pend_next = 1'b0;
        self_pend_next = 1'b0;
        w_pend_next    = w_pend_reg;
        h_next         = h_reg;
        self_spin_next = self_pend_reg ? spin_q_reg : self_spin_reg;
        de_next        = de_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next   = CLR_W'(clr_reg + 1'b1);
                edge_we    = ({1'b0, clr_reg} < CLR_EDGE);
                edge_waddr = clr_reg[EDGE_AW-1:0];
                spin_we    = ({1'b0, clr_reg} < CLR_SPIN);
                spin_waddr = clr_reg[VIDX_W-1:0];
                thr_we     = ({1'b0, clr_reg} < CLR_TABLE);
                thr_waddr  = clr_reg[TABLE_AW-1:0];
                thr_wdata  = '0;
            end
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    op_take        = 1'b1;
                    op_next        = op;
                    vidx_next      = vidx_in;
                    edge_addr_next = edge_addr_in;
                    k_next         = '0;
                    h_next         = '0;
                    de_next        = '0;
                end
            end
            ST_SELF:
            begin
                // The vertex spin is read here for every command but a no-op; writes land
                // in the same cycle and the read returns the old value.
                spin_re        = 1'b1;
                self_pend_next = 1'b1;
                case (op_reg.kind)
                    OP_EDGE:
                    begin
                        edge_we    = op_reg.slot_ok;
                        edge_wdata = {op_reg.neighbor, weight_wide[WEIGHT_BITS-1:0]};
                    end
                    OP_SPIN:
                    begin
                        spin_we    = 1'b1;
                        spin_wdata = op_reg.spin_bit;
                    end
                    OP_THRESH:
                    begin
                        thr_we = 1'b1;
                    end
                    OP_METRO, OP_GREEDY, OP_READ:
                    begin
                        edge_re        = 1'b1;
                        edge_addr_next = EDGE_AW'(edge_addr_reg + 1'b1);
                        k_next         = K_W'(1);
                        edge_pend_next = 1'b1;
                    end
                    default:
                    begin
                        edge_re = 1'b0;
                    end
                endcase
            end
            ST_TRY:
            begin
                // Three-deep pipe: slot read, neighbor spin read, accumulate.
                if (k_reg < K_LAST)
                begin
                    edge_re        = 1'b1;
                    edge_addr_next = EDGE_AW'(edge_addr_reg + 1'b1);
                    k_next         = K_W'(k_reg + 1'b1);
                    edge_pend_next = 1'b1;
                end
                if (edge_pend_reg)
                begin
                    spin_re        = nb_ok;
                    spin_raddr     = VIDX_W'(edge_nb);
                    spin_pend_next = nb_ok;
                    w_pend_next    = edge_w;
                end
                if (spin_pend_reg)
                begin
                    h_next = spin_q_reg ? (h_reg + w_ext) : (h_reg - w_ext);
                end
            end
            ST_ENERGY:
            begin
                de_next = de_calc;
                thr_re  = 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    if (op_reg.kind == OP_NOP)
                    begin
                        res_next = '0;
                    end
                    else
                    begin
                        res_next.flipped       = flip;
                        res_next.spin_now      = (op_reg.kind == OP_SPIN) ? op_reg.spin_bit
                                                                        : (self_spin_reg ^ flip);
                        res_next.energy_change = de_sat;
                    end
                    spin_we    = flip;
                    spin_wdata = !self_spin_reg;
                end
            end
            default:
            begin
                op_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            edge_pend_reg <= 1'b0;
            spin_pend_reg <= 1'b0;
            self_pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            edge_pend_reg <= edge_pend_next;
            spin_pend_reg <= spin_pend_next;
            self_pend_reg <= self_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        vidx_reg      <= vidx_next;
        edge_addr_reg <= edge_addr_next;
        w_pend_reg    <= w_pend_next;
        h_reg         <= h_next;
        self_spin_reg <= self_spin_next;
        de_reg        <= de_next;
        res_reg       <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        if (edge_re)
        begin
            edge_q_reg <= edge_mem[edge_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (spin_we)
        begin
            spin_mem[spin_waddr] <= spin_wdata;
        end
        if (spin_re)
        begin
            spin_q_reg <= spin_mem[spin_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (thr_we)
        begin
            thr_mem[thr_waddr] <= thr_wdata;
        end
        if (thr_re)
        begin
            thr_q_reg <= thr_mem[thr_raddr];
        end
    end

endmodule

[design/ising_metropolis_spin_update.sv]
// ============================================================================
// Ising Metropolis spin update
// One Ising replica with spin, coupling and threshold storage and a
// Metropolis or greedy single-spin flip engine behind a queue interface.
// ============================================================================
// Commands enter through a push/full queue port and results leave through an
// empty/pop queue port, one result per command, in command order. After reset
// the block sweeps its memories to zero, one address per cycle, over
// max(NUM_VERTICES * MAX_DEGREE, 1024) addresses (8192 with the defaults); full
// stays high for that whole sweep. A front end decodes each command and
// checks its vertex, then parks it in a two-entry queue, so new commands are
// taken while the back end works. The back end runs one command at a time.
// A Metropolis try, greedy try or read walks the vertex's coupling slots one
// per cycle through a three-stage pipe (slot read, neighbor spin read,
// accumulate) and then reads the acceptance threshold. The single read port
// of the coupling memory sets that pace. Loading an edge, setting a spin or
// loading a threshold does its write and skips the slot walk, and a command
// with an unused code or an out-of-range vertex goes straight to the result
// and returns all-zero fields. A finished result waits in an output register
// until its transfer, while the front end keeps taking commands until its queue
// is full. Thresholds are loaded by software as
// floor(exp(-beta*dE) * 65536); the table is indexed with dE/2, clamped to
// its last entry, and a value of 65536 always accepts.
module ising_metropolis_spin_update #(
    parameter int NUM_VERTICES = 1024,
    parameter int MAX_DEGREE   = 8,
    parameter int WEIGHT_BITS  = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ising_pkg::in_item_t  item,
    output logic                 empty,
    input  logic                 pop,
    output ising_pkg::out_item_t result
);
    import ising_pkg::*;

    logic op_valid;
    logic op_take;
    op_t  op;
    logic clearing;

    // Decode and queue; input transfers are blocked while memories clear.
    ising_front #(
        .NUM_VERTICES (NUM_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (clearing),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_valid (op_valid),
        .op_take  (op_take),
        .op       (op)
    );

    // Execution engine with the memories and the result register.
    ising_back #(
        .NUM_VERTICES (NUM_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_take  (op_take),
        .op       (op),
        .clearing (clearing),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // No command may enter while the memories are still being cleared.
    a_clear_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> full
    ) else $error("input accepted during memory clear");

    // The back end only takes a command when the queue holds one.
    a_take_needs_entry: assert property (
        @(posedge clk) disable iff (!rst_n) op_take |-> op_valid
    ) else $error("command taken from an empty queue");

    // The back end does not take commands during the clearing sweep.
    a_no_take_in_clear: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> !op_take
    ) else $error("command taken during memory clear");

    // No result can exist when the clearing sweep ends.
    a_no_result_after_clear: assert property (
        @(posedge clk) disable iff (!rst_n) $fell(clearing) |-> empty
    ) else $error("result present at end of memory clear");

endmodule

[dv/ising_metropolis_spin_update_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// Ising Metropolis spin update testbench
// Drives command items through the push/full port and checks each result
// popped from the empty/pop port against an in-order predictor of the
// replica state, under random idling on both sides.
// ============================================================================
module ising_metropolis_spin_update_tb;

    import ising_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int VERTICES      = 1024;
    localparam int DEGREE        = 8;
    localparam int DIRECTED_MAX  = 25;
    localparam int RANDOM_ITEMS  = 1050;
    // Once more than this many commands have gone in, later episodes stop idling on both sides.
    localparam int CALM_AFTER    = 920;
    // The reset sweep alone keeps full high while it clears all 8192 addresses, so
    // the limit on cycles without any transfer sits well above the sweep.
    localparam int STALL_LIMIT   = 40000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int SATURATED_HI  = 2047;
    localparam int SATURATED_LO  = -2048;
    localparam int FULL_SCALE    = 65536;

    // Command codes that the block does not define; they must come back as
    // all-zero results and leave the state alone.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    logic      full;
    logic      empty;
    in_item_t  item  = '0;
    out_item_t result;

    // Percentage chance that a transfer on either side is preceded by an
    // idle burst. Zero gives stretches with no idling at all.
    int gap_pct = 0;
    int sent    = 0;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the replica (spins, coupling slots,
    // acceptance thresholds), works out the result of every accepted command
    // in order, and compares popped results against the oldest outcome.
    // ------------------------------------------------------------------------
    class spin_flip_scoreboard;
        bit                         spin_state   [VERTICES];
        logic [NEIGHBOR_W-1:0]      edge_neighbor [VERTICES*DEGREE];
        logic signed [WEIGHT_W-1:0] edge_weight  [VERTICES*DEGREE];
        logic [THRESH_W-1:0]        accept_level [TABLE_DEPTH];
        out_item_t                  outcomes [$];
        int                         errors;

        function new();
            foreach (spin_state[i]) spin_state[i] = 1'b0;
            foreach (edge_neighbor[i]) edge_neighbor[i] = '0;
            foreach (edge_weight[i]) edge_weight[i] = '0;
            foreach (accept_level[i]) accept_level[i] = '0;
            errors = 0;
        endfunction

        // Energy change of flipping vertex v, with spins read as +1 / -1.
        // Every neighbor index fits the vertex range, so every slot counts;
        // an empty slot simply has weight zero.
        function int flip_cost(int v);
            int field = 0;
            int slot_at;
            for (int k = 0; k < DEGREE; k++)
            begin
                slot_at = v * DEGREE + k;
                field += int'(edge_weight[slot_at]) *
                         (spin_state[edge_neighbor[slot_at]] ? 1 : -1);
            end
            return spin_state[v] ? -2 * field : 2 * field;
        endfunction

        function void note_command(in_item_t cmd_in);
            out_item_t outcome;
            int        v;
            int        de;
            int        row;
            bit        flip;
            outcome = '0;
            v       = int'(cmd_in.vertex);
            case (cmd_in.command)
                CMD_LOAD_EDGE:
                begin
                    edge_neighbor[v * DEGREE + int'(cmd_in.slot)] = cmd_in.neighbor;
                    edge_weight[v * DEGREE + int'(cmd_in.slot)]   = cmd_in.weight;
                end
                CMD_SET_SPIN:
                    spin_state[v] = cmd_in.spin_bit;
                CMD_LOAD_THRESH:
                    accept_level[cmd_in.table_index] = cmd_in.table_value;
                CMD_METRO, CMD_GREEDY, CMD_READ:
                begin
                    // The change is taken before any flip.
                    de   = flip_cost(v);
                    flip = 1'b0;
                    if (cmd_in.command == CMD_METRO)
                    begin
                        // Entry dE/2, clamped to the last entry of the table.
                        row = (de < 0) ? 0 : de / 2;
                        if (row > TABLE_DEPTH - 1)
                            row = TABLE_DEPTH - 1;
                        flip = (de < 0) ||
                               ({1'b0, cmd_in.random_word} < accept_level[row]);
                    end
                    else if (cmd_in.command == CMD_GREEDY)
                        flip = (de < 0);
                    if (flip)
                        spin_state[v] = ~spin_state[v];
                    if (de > SATURATED_HI)
                        de = SATURATED_HI;
                    if (de < SATURATED_LO)
                        de = SATURATED_LO;
                    outcome.flipped       = flip;
                    outcome.energy_change = de[DE_W-1:0];
                end
                default:
                    ;
            endcase
            if (cmd_in.command <= CMD_READ)
                outcome.spin_now = spin_state[v];
            outcomes.insert(outcomes.size(), outcome);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (outcomes.size() == 0)
            begin
                report($sformatf("result %h with no command outstanding", got));
                return;
            end
            want = outcomes.pop_front();
            if (got.flipped !== want.flipped)
                report($sformatf("flipped got %b want %b", got.flipped, want.flipped));
            if (got.spin_now !== want.spin_now)
                report($sformatf("spin_now got %b want %b", got.spin_now, want.spin_now));
            if (got.energy_change !== want.energy_change)
                report($sformatf("energy_change got %0d want %0d",
                                 got.energy_change, want.energy_change));
        endtask
    endclass

    spin_flip_scoreboard sb = new();

    ising_metropolis_spin_update dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Transfer monitor. Both ports are sampled at the rising edge, before any
    // of this edge's nonblocking updates land, so a transfer is seen exactly
    // when the block sees it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_command(item);
            if (pop && !empty)
                sb.check_result(result);
        end
    end

    // Watchdog: the run is declared hung when the count of samples with no
    // transfer on either port, cleared by any transfer, reaches STALL_LIMIT.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: pop stays high except during random idle bursts.
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            if (gap_pct != 0 && $urandom_range(99) < gap_pct)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Command side helpers.
    // ------------------------------------------------------------------------

    // Fully random item: every field bit, unused command codes included.
    function automatic in_item_t noise_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return in_item_t'(raw[$bits(in_item_t)-1:0]);
    endfunction

    // Random filler in the fields a command ignores keeps every bit moving.
    function automatic in_item_t make_cmd(logic [2:0] code, int v);
        in_item_t it;
        it         = noise_item();
        it.command = code;
        it.vertex  = VERTEX_W'(v);
        return it;
    endfunction

    // Holds the item on the port until the block takes it. An idle burst may
    // come first; push is never lowered and raised again within one step.
    task automatic send(in_item_t it);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge clk);
        end
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    task automatic load_edge(int v, int s, int n, int w);
        in_item_t it;
        it          = make_cmd(CMD_LOAD_EDGE, v);
        it.slot     = SLOT_W'(s);
        it.neighbor = NEIGHBOR_W'(n);
        it.weight   = WEIGHT_W'(w);
        send(it);
    endtask

    task automatic set_spin(int v, int b);
        in_item_t it;
        it          = make_cmd(CMD_SET_SPIN, v);
        it.spin_bit = b[0];
        send(it);
    endtask

    task automatic load_threshold(int idx, int level);
        in_item_t it;
        it             = make_cmd(CMD_LOAD_THRESH, 0);
        it.table_index = TABLE_AW'(idx);
        it.table_value = THRESH_W'(level);
        send(it);
    endtask

    task automatic try_flip(logic [2:0] code, int v, int rnd);
        in_item_t it;
        it             = make_cmd(code, v);
        it.random_word = RANDOM_W'(rnd);
        send(it);
    endtask

    // One episode builds a small random graph on eight vertices spread over
    // the whole index range, sets their spins, loads some thresholds and
    // then runs many tries on it, with a little noise mixed in. In a quarter
    // of the episodes the weights span the full signed range and thresholds
    // go anywhere in the table; otherwise weights stay small so that dE/2
    // lands on the few low entries that were loaded.
    task automatic run_episode();
        int pool [8];
        bit wide;
        int w;
        if (sent > CALM_AFTER)
            gap_pct = 0;
        else
            case ($urandom_range(2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
        wide = ($urandom_range(3) == 0);
        foreach (pool[i])
            pool[i] = $urandom_range(VERTICES - 1);
        repeat ($urandom_range(24, 8))
        begin
            w = wide ? int'($urandom_range(255)) - 128 : int'($urandom_range(8)) - 4;
            load_edge(pool[$urandom_range(7)], $urandom_range(DEGREE - 1),
                      pool[$urandom_range(7)], w);
        end
        foreach (pool[i])
            set_spin(pool[i], $urandom_range(1));
        repeat ($urandom_range(8, 3))
            load_threshold($urandom_range(wide ? TABLE_DEPTH - 1 : 24),
                           ($urandom_range(7) == 0) ? FULL_SCALE
                                                    : $urandom_range(FULL_SCALE - 1));
        repeat ($urandom_range(40, 20))
        begin
            if ($urandom_range(15) == 0)
                send(noise_item());
            else
                case ($urandom_range(3))
                    0:       try_flip(CMD_GREEDY, pool[$urandom_range(7)], 0);
                    1:       try_flip(CMD_READ, pool[$urandom_range(7)], $urandom);
                    default: try_flip(CMD_METRO, pool[$urandom_range(7)],
                                      $urandom_range(FULL_SCALE - 1));
                endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Right after reset every store is clear: a read sees a zero change
        // and a Metropolis try at zero change is rejected by the empty table.
        try_flip(CMD_READ, 0, 0);
        try_flip(CMD_METRO, 0, 0);

        // Unused command codes return all-zero fields.
        send(make_cmd(CMD_SPARE_A, 3));
        send(make_cmd(CMD_SPARE_B, VERTICES - 1));

        // Vertex 1023 gets eight of the most negative couplings to a neighbor
        // that points the same way: dE is 2048, which saturates the output
        // and clamps the table index to its last entry. That entry holds the
        // full-scale threshold, so even the largest random word accepts.
        for (int k = 0; k < DEGREE; k++)
            load_edge(VERTICES - 1, k, VERTICES - 2, -128);
        set_spin(VERTICES - 2, 1);
        set_spin(VERTICES - 1, 1);
        load_threshold(TABLE_DEPTH - 1, FULL_SCALE);
        try_flip(CMD_METRO, VERTICES - 1, FULL_SCALE - 1);
        // After that flip the change is at its most negative; greedy flips back.
        try_flip(CMD_READ, VERTICES - 1, 0);
        try_flip(CMD_GREEDY, VERTICES - 1, 0);

        // A self loop entered twice at the largest positive weight: the
        // vertex's own spin is read before the flip and both slots add up.
        load_edge(0, 0, 0, 127);
        load_edge(0, DEGREE - 1, 0, 127);
        try_flip(CMD_GREEDY, 0, 0);

        // A vertex with no couplings has zero change and uses entry 0; the
        // random word equal to the threshold rejects, one below accepts.
        load_threshold(0, 100);
        try_flip(CMD_METRO, 5, 100);
        try_flip(CMD_METRO, 5, 99);

        while (sent < DIRECTED_MAX + RANDOM_ITEMS)
            run_episode();
        push <= 1'b0;

        // Let every outstanding result come out, then watch a little longer
        // for anything unexpected.
        while (sb.outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.outcomes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
